### src/pvc_pkg.sv
// Shared constants and types for the polyhedron volume and centre block.
// Used by the channel interfaces and by the top level; depends on nothing.
package pvc_pkg;

    localparam int DEF_MAX_VERTS  = 256;
    localparam int DEF_MAX_FACES  = 32;
    localparam int DEF_COORD_BITS = 12;

    // Fixed field widths of the channels.
    localparam int COORD_W = 12;
    localparam int VOL_W   = 50;
    localparam int CEN_W   = 16;

    // Internal arithmetic widths.
    localparam int DIFF_W  = COORD_W + 1;     // vertex minus face centre
    localparam int SUM4_W  = COORD_W + 2;     // sum of four points
    localparam int CR_W    = 27;              // one cross product term
    localparam int DET_W   = 42;              // six-fold signed volume
    localparam int MUL_A_W = 28;
    localparam int MUL_B_W = 15;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SPLIT_W = DET_W / 2;       // |d| is multiplied in two halves
    localparam int ACC_W   = 64;
    localparam int DVD_W   = ACC_W + 2;       // four times the weighted sum
    localparam int QUO_W   = 17;              // quotient bits kept by the divider

    localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};
    localparam logic signed [CEN_W-1:0] CEN_POS_MAX = 16'sh7FFF;
    localparam logic signed [CEN_W-1:0] CEN_NEG_MAX = 16'sh8000;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [CEN_W-1:0]   cen_t;

endpackage

### src/pvc_vtx_if.sv
// Vertex input channel: valid/ready handshake with one vertex per transaction.
// Depends on pvc_pkg for the coordinate type.
interface pvc_vtx_if;
    logic            valid;
    logic            ready;
    pvc_pkg::coord_t vx;
    pvc_pkg::coord_t vy;
    pvc_pkg::coord_t vz;
    pvc_pkg::coord_t fcx;
    pvc_pkg::coord_t fcy;
    pvc_pkg::coord_t fcz;
    logic            face_end;
    logic            cell_end;

    modport source (output valid, vx, vy, vz, fcx, fcy, fcz, face_end, cell_end,
                    input ready);
    modport sink   (input valid, vx, vy, vz, fcx, fcy, fcz, face_end, cell_end,
                    output ready);
endinterface

### src/pvc_res_if.sv
// Result channel: valid/ready handshake with one cell result per transaction.
// Depends on pvc_pkg for widths and the centre type.
interface pvc_res_if;
    logic                      valid;
    logic                      ready;
    logic [pvc_pkg::VOL_W-1:0] volume_x6;
    pvc_pkg::cen_t             centre_x;
    pvc_pkg::cen_t             centre_y;
    pvc_pkg::cen_t             centre_z;
    logic                      degenerate;
    logic                      overflow;

    modport source (output valid, volume_x6, centre_x, centre_y, centre_z,
                    degenerate, overflow, input ready);
    modport sink   (input valid, volume_x6, centre_x, centre_y, centre_z,
                    degenerate, overflow, output ready);
endinterface

### src/polyhedron_volume_centroid.sv
// Volume and centre of one polyhedral cell by tetrahedral decomposition.
// Depends on pvc_pkg, pvc_vtx_if and pvc_res_if.
//
// Usage: vertices of one cell arrive on the vtx channel, face by face, one
// vertex per transaction. Each vertex carries its face centre; face_end marks
// the last vertex of a face and cell_end the last vertex of the cell.
// While vertices load, vtx.ready is high and one vertex is taken per cycle.
// After cell_end the block drops vtx.ready and runs its end-of-cell pass:
// one shared multiplier and one shared restoring divider work under a small
// sequencer. The pass runs six divisions (three for the mean of the face
// centres, three for the cell centre), fetches each stored face and runs
// the multiplier steps of each tetrahedron. Cells with zero volume skip
// the centre divisions.
// The result goes into an output register and the block takes vertices of
// the next cell at once; if that cell ends while the previous result is
// still not taken, the block waits in its final step until res.ready.
// Reset (rst_n low, asynchronous) empties the cell, drops res.valid and
// leaves the vertex and face stores with stale contents that are never read.
module polyhedron_volume_centroid #(
    parameter int MAX_VERTS  = pvc_pkg::DEF_MAX_VERTS,
    parameter int MAX_FACES  = pvc_pkg::DEF_MAX_FACES,
    parameter int COORD_BITS = pvc_pkg::DEF_COORD_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    pvc_vtx_if.sink   vtx,
    pvc_res_if.source res
);

    localparam int VA_W  = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
    localparam int VC_W  = $clog2(MAX_VERTS + 1);
    localparam int FA_W  = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int FC_W  = $clog2(MAX_FACES + 1);
    localparam int FS_W  = pvc_pkg::COORD_W + FC_W;
    localparam int CW    = pvc_pkg::COORD_W;
    localparam int VROW  = 3 * CW;
    localparam int FROW  = 3 * CW + VC_W;
    localparam int QW    = pvc_pkg::QUO_W;
    localparam int VW    = pvc_pkg::VOL_W;
    localparam int AW    = pvc_pkg::ACC_W;
    localparam int DW    = pvc_pkg::DVD_W;
    localparam int SW    = pvc_pkg::SPLIT_W;

    typedef enum logic [3:0] {
        S_LOAD, S_DIV_SET, S_DIV_RUN, S_DIV_END, S_FACE_RD, S_FACE_GET,
        S_FIRST, S_NEXT_RD, S_NEXT_GET, S_TETRA, S_FINISH
    } state_t;

    typedef enum logic {DM_MEAN, DM_CENTRE} div_mode_t;

    // Steps of one tetrahedron on the shared multiplier.
    typedef enum logic [4:0] {
        T_B1C2, T_B2C1, T_B2C0, T_B0C2, T_B0C1, T_B1C0, T_CR2, T_DOT1, T_DOT2,
        T_DOT3, T_ABS, T_VOL, T_WX_HI, T_WY_LO, T_WY_HI, T_WZ_LO, T_WZ_HI, T_WZ_END
    } tstep_t;

    // Keeps the low COORD_BITS bits of a field as a two's complement number.
    function automatic pvc_pkg::coord_t sext_c(input logic [CW-1:0] v);
        pvc_pkg::coord_t r;
        for (int i = 0; i < CW; i++) begin
            r[i] = (i < COORD_BITS) ? v[i] : v[COORD_BITS-1];
        end
        return r;
    endfunction

    // Stores. The vertex and face stores are only read below their fill counts.
    logic [VROW-1:0] vmem  [MAX_VERTS];
    logic [FA_W-1:0] idmem [MAX_VERTS];
    logic [FROW-1:0] fmem  [MAX_FACES];
    logic [VROW-1:0] vrd_reg;
    logic [FA_W-1:0] idrd_reg;
    logic [FROW-1:0] frd_reg;
    logic [VA_W-1:0] va;

    state_t    state_reg;
    div_mode_t mode_reg;
    tstep_t    ph_reg;

    // Per-cell accumulation.
    logic signed [FS_W-1:0] fsum_reg [3];
    logic [VC_W-1:0]        vc_reg;
    logic [VC_W-1:0]        open_reg;
    logic [FC_W-1:0]        fc_reg;
    logic [VW-1:0]          vol_reg;
    logic signed [AW-1:0]   w_reg [3];
    logic                   ovf_reg;

    // Pass walk.
    logic [FC_W-1:0]  f_reg;
    logic [VC_W-1:0]  j_reg;
    logic [VC_W-1:0]  start_reg;
    logic             wrap_reg;
    pvc_pkg::coord_t  n_reg    [3];
    pvc_pkg::coord_t  fcen_reg [3];
    pvc_pkg::coord_t  first_reg[3];
    pvc_pkg::coord_t  cur_reg  [3];
    pvc_pkg::coord_t  nxt_reg  [3];
    pvc_pkg::coord_t  vrd_c    [3];

    // Multiplier path.
    logic signed [pvc_pkg::MUL_A_W-1:0] mul_a;
    logic signed [pvc_pkg::MUL_B_W-1:0] mul_b;
    logic signed [pvc_pkg::PROD_W-1:0]  p_reg;
    logic signed [pvc_pkg::CR_W-1:0]    x_reg;
    logic signed [pvc_pkg::CR_W-1:0]    cr_reg [3];
    logic signed [pvc_pkg::DET_W-1:0]   d_reg;
    logic [pvc_pkg::DET_W-1:0]          ad_reg;
    logic signed [pvc_pkg::DIFF_W-1:0]  a_d [3];
    logic signed [pvc_pkg::DIFF_W-1:0]  b_d [3];
    logic signed [pvc_pkg::DIFF_W-1:0]  c_d [3];
    logic signed [pvc_pkg::SUM4_W-1:0]  s_d [3];
    logic signed [AW-1:0]               p_ext;
    logic [VW:0]                        vol_sum;

    // Divider.
    logic [1:0]             axis_reg;
    logic [VW-1:0]          rem_reg;
    logic [QW-1:0]          low_reg;
    logic [QW-1:0]          q_reg;
    logic [4:0]             cnt_reg;
    logic                   neg_reg;
    logic                   sat_reg;
    logic [DW-1:0]          set_dvd;
    logic                   set_neg;
    logic [VW-1:0]          dvs;
    logic [VW:0]            trial;
    logic                   trial_ge;
    pvc_pkg::cen_t          cen_reg [3];

    // Result register.
    logic                   res_valid_reg;
    logic [VW-1:0]          res_vol_reg;
    pvc_pkg::cen_t          res_cen_reg [3];
    logic                   res_deg_reg;
    logic                   res_ovf_reg;
    logic                   res_load;

    // Intake decode.
    pvc_pkg::coord_t in_c [3];
    pvc_pkg::coord_t fin_c[3];
    logic            acc_in;
    logic            fe;
    logic            v_store;
    logic            f_store;
    logic [VC_W-1:0] vc_after;
    logic [FC_W-1:0] fc_after;
    logic [FC_W-1:0] f_inc;
    logic            last_face;
    logic [VC_W-1:0] j_inc;
    logic            first_ok;
    logic            next_ok;

    assign in_c[0]  = sext_c(vtx.vx);
    assign in_c[1]  = sext_c(vtx.vy);
    assign in_c[2]  = sext_c(vtx.vz);
    assign fin_c[0] = sext_c(vtx.fcx);
    assign fin_c[1] = sext_c(vtx.fcy);
    assign fin_c[2] = sext_c(vtx.fcz);

    assign vtx.ready = (state_reg == S_LOAD);
    assign acc_in    = vtx.valid & vtx.ready;
    assign fe        = vtx.face_end | vtx.cell_end;
    assign v_store   = vc_reg < VC_W'(MAX_VERTS);
    assign f_store   = fc_reg < FC_W'(MAX_FACES);
    assign vc_after  = v_store ? vc_reg + 1'b1 : vc_reg;
    assign fc_after  = (fe && f_store) ? fc_reg + 1'b1 : fc_reg;
    assign f_inc     = f_reg + 1'b1;
    assign last_face = f_inc >= fc_reg;
    assign j_inc     = j_reg + 1'b1;
    assign first_ok  = (start_reg < vc_reg) && (idrd_reg == f_reg[FA_W-1:0]);
    assign next_ok   = (j_inc < vc_reg) && (idrd_reg == f_reg[FA_W-1:0]);

    // A new result is loaded once the output register is free or being taken.
    assign res_load  = (state_reg == S_FINISH) && (!res_valid_reg || res.ready);

    assign vrd_c[0] = vrd_reg[CW-1:0];
    assign vrd_c[1] = vrd_reg[2*CW-1:CW];
    assign vrd_c[2] = vrd_reg[3*CW-1:2*CW];

    // Vertex read address: the first vertex of a face, else the one after j.
    always_comb
    begin
        case (state_reg)
            S_FACE_GET: va = frd_reg[VA_W-1:0];
            default:    va = j_inc[VA_W-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (acc_in && v_store)
        begin
            vmem[vc_reg[VA_W-1:0]]  <= {in_c[2], in_c[1], in_c[0]};
            idmem[vc_reg[VA_W-1:0]] <= fc_reg[FA_W-1:0];
        end
        vrd_reg  <= vmem[va];
        idrd_reg <= idmem[va];
    end

    always_ff @(posedge clk)
    begin
        if (acc_in && fe && f_store)
        begin
            fmem[fc_reg[FA_W-1:0]] <= {fin_c[2], fin_c[1], fin_c[0], open_reg};
        end
        frd_reg <= fmem[f_reg[FA_W-1:0]];
    end

    // Tetrahedron edges relative to the face centre, and four-point sums.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            a_d[k] = pvc_pkg::DIFF_W'(cur_reg[k]) - pvc_pkg::DIFF_W'(fcen_reg[k]);
            b_d[k] = pvc_pkg::DIFF_W'(nxt_reg[k]) - pvc_pkg::DIFF_W'(fcen_reg[k]);
            c_d[k] = pvc_pkg::DIFF_W'(n_reg[k])   - pvc_pkg::DIFF_W'(fcen_reg[k]);
            s_d[k] = pvc_pkg::SUM4_W'(cur_reg[k]) + pvc_pkg::SUM4_W'(nxt_reg[k])
                   + pvc_pkg::SUM4_W'(fcen_reg[k]) + pvc_pkg::SUM4_W'(n_reg[k]);
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ph_reg)
            T_B1C2:  begin mul_a = pvc_pkg::MUL_A_W'(b_d[1]); mul_b = pvc_pkg::MUL_B_W'(c_d[2]); end
            T_B2C1:  begin mul_a = pvc_pkg::MUL_A_W'(b_d[2]); mul_b = pvc_pkg::MUL_B_W'(c_d[1]); end
            T_B2C0:  begin mul_a = pvc_pkg::MUL_A_W'(b_d[2]); mul_b = pvc_pkg::MUL_B_W'(c_d[0]); end
            T_B0C2:  begin mul_a = pvc_pkg::MUL_A_W'(b_d[0]); mul_b = pvc_pkg::MUL_B_W'(c_d[2]); end
            T_B0C1:  begin mul_a = pvc_pkg::MUL_A_W'(b_d[0]); mul_b = pvc_pkg::MUL_B_W'(c_d[1]); end
            T_B1C0:  begin mul_a = pvc_pkg::MUL_A_W'(b_d[1]); mul_b = pvc_pkg::MUL_B_W'(c_d[0]); end
            T_CR2:   begin mul_a = pvc_pkg::MUL_A_W'(cr_reg[0]); mul_b = pvc_pkg::MUL_B_W'(a_d[0]); end
            T_DOT1:  begin mul_a = pvc_pkg::MUL_A_W'(cr_reg[1]); mul_b = pvc_pkg::MUL_B_W'(a_d[1]); end
            T_DOT2:  begin mul_a = pvc_pkg::MUL_A_W'(cr_reg[2]); mul_b = pvc_pkg::MUL_B_W'(a_d[2]); end
            T_VOL:   begin mul_a = $signed(pvc_pkg::MUL_A_W'(ad_reg[SW-1:0]));
                           mul_b = pvc_pkg::MUL_B_W'(s_d[0]); end
            T_WX_HI: begin mul_a = $signed(pvc_pkg::MUL_A_W'(ad_reg[2*SW-1:SW]));
                           mul_b = pvc_pkg::MUL_B_W'(s_d[0]); end
            T_WY_LO: begin mul_a = $signed(pvc_pkg::MUL_A_W'(ad_reg[SW-1:0]));
                           mul_b = pvc_pkg::MUL_B_W'(s_d[1]); end
            T_WY_HI: begin mul_a = $signed(pvc_pkg::MUL_A_W'(ad_reg[2*SW-1:SW]));
                           mul_b = pvc_pkg::MUL_B_W'(s_d[1]); end
            T_WZ_LO: begin mul_a = $signed(pvc_pkg::MUL_A_W'(ad_reg[SW-1:0]));
                           mul_b = pvc_pkg::MUL_B_W'(s_d[2]); end
            T_WZ_HI: begin mul_a = $signed(pvc_pkg::MUL_A_W'(ad_reg[2*SW-1:SW]));
                           mul_b = pvc_pkg::MUL_B_W'(s_d[2]); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign p_ext   = AW'(p_reg);
    assign vol_sum = {1'b0, vol_reg} + (VW + 1)'(ad_reg);

    // Divider operands: the mean of the face centres, or four times the
    // weighted sum over the volume.
    always_comb
    begin
        logic signed [FS_W-1:0] fs;
        logic signed [AW-1:0]   w;
        logic [AW-1:0]          wmag;
        fs = fsum_reg[axis_reg];
        w  = w_reg[axis_reg];
        wmag = w[AW-1] ? AW'(-w) : AW'(w);
        if (mode_reg == DM_MEAN)
        begin
            set_neg = fs[FS_W-1];
            set_dvd = fs[FS_W-1] ? DW'(unsigned'(-fs)) : DW'(unsigned'(fs));
            dvs     = VW'(fc_reg);
        end
        else
        begin
            set_neg = w[AW-1];
            set_dvd = {wmag, 2'b00};
            dvs     = vol_reg;
        end
    end

    assign trial    = {rem_reg, low_reg[QW-1]};
    assign trial_ge = trial >= {1'b0, dvs};

    always_ff @(posedge clk)
    begin
        p_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            mode_reg      <= DM_MEAN;
            ph_reg        <= T_B1C2;
            for (int k = 0; k < 3; k++)
            begin
                fsum_reg[k] <= '0;
                w_reg[k]    <= '0;
            end
            vc_reg        <= '0;
            open_reg      <= '0;
            fc_reg        <= '0;
            vol_reg       <= '0;
            ovf_reg       <= 1'b0;
            f_reg         <= '0;
            axis_reg      <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_LOAD:
                begin
                    if (acc_in)
                    begin
                        if (fe && !f_store)
                        begin
                            // Face store full: the whole face is released.
                            vc_reg <= open_reg;
                        end
                        else
                        begin
                            vc_reg <= vc_after;
                        end
                        if (!v_store || (fe && !f_store))
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (fe && f_store)
                        begin
                            for (int k = 0; k < 3; k++)
                            begin
                                fsum_reg[k] <= fsum_reg[k] + FS_W'(fin_c[k]);
                            end
                            fc_reg   <= fc_reg + 1'b1;
                            open_reg <= vc_after;
                        end
                        if (vtx.cell_end)
                        begin
                            f_reg    <= '0;
                            axis_reg <= '0;
                            mode_reg <= DM_MEAN;
                            state_reg <= (fc_after == '0) ? S_FINISH : S_DIV_SET;
                        end
                    end
                end

                S_DIV_SET:
                begin
                    rem_reg   <= VW'(set_dvd[DW-1:QW]);
                    low_reg   <= set_dvd[QW-1:0];
                    sat_reg   <= VW'(set_dvd[DW-1:QW]) >= dvs;
                    neg_reg   <= set_neg;
                    q_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV_RUN;
                end

                S_DIV_RUN:
                begin
                    rem_reg <= trial_ge ? VW'(trial - {1'b0, dvs}) : trial[VW-1:0];
                    low_reg <= {low_reg[QW-2:0], 1'b0};
                    q_reg   <= {q_reg[QW-2:0], trial_ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'(QW - 1))
                    begin
                        state_reg <= S_DIV_END;
                    end
                end

                S_DIV_END:
                begin
                    axis_reg <= axis_reg + 1'b1;
                    if (mode_reg == DM_MEAN)
                    begin
                        n_reg[axis_reg] <= neg_reg ? -q_reg[CW-1:0] : q_reg[CW-1:0];
                        state_reg <= (axis_reg == 2'd2) ? S_FACE_RD : S_DIV_SET;
                    end
                    else
                    begin
                        if (neg_reg)
                        begin
                            cen_reg[axis_reg] <= (sat_reg || q_reg > QW'(32768)) ?
                                pvc_pkg::CEN_NEG_MAX : -q_reg[pvc_pkg::CEN_W-1:0];
                        end
                        else
                        begin
                            cen_reg[axis_reg] <= (sat_reg || q_reg > QW'(32767)) ?
                                pvc_pkg::CEN_POS_MAX : q_reg[pvc_pkg::CEN_W-1:0];
                        end
                        state_reg <= (axis_reg == 2'd2) ? S_FINISH : S_DIV_SET;
                    end
                end

                S_FACE_RD:
                begin
                    state_reg <= S_FACE_GET;
                end

                S_FACE_GET:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        fcen_reg[k] <= frd_reg[VC_W + k*CW +: CW];
                    end
                    start_reg <= frd_reg[VC_W-1:0];
                    state_reg <= S_FIRST;
                end

                S_FIRST:
                begin
                    if (first_ok)
                    begin
                        first_reg <= vrd_c;
                        cur_reg   <= vrd_c;
                        j_reg     <= start_reg;
                        state_reg <= S_NEXT_RD;
                    end
                    else
                    begin
                        // A face with no stored vertices adds no tetrahedra.
                        f_reg <= f_inc;
                        if (!last_face)
                        begin
                            state_reg <= S_FACE_RD;
                        end
                        else if (vol_reg == '0)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            mode_reg  <= DM_CENTRE;
                            axis_reg  <= '0;
                            state_reg <= S_DIV_SET;
                        end
                    end
                end

                S_NEXT_RD:
                begin
                    state_reg <= S_NEXT_GET;
                end

                S_NEXT_GET:
                begin
                    nxt_reg   <= next_ok ? vrd_c : first_reg;
                    wrap_reg  <= !next_ok;
                    ph_reg    <= T_B1C2;
                    state_reg <= S_TETRA;
                end

                S_TETRA:
                begin
                    ph_reg <= tstep_t'(ph_reg + 1'b1);
                    case (ph_reg)
                        T_B1C2:  ;
                        T_B2C1:  x_reg <= p_reg[pvc_pkg::CR_W-1:0];
                        T_B2C0:  cr_reg[0] <= x_reg - p_reg[pvc_pkg::CR_W-1:0];
                        T_B0C2:  x_reg <= p_reg[pvc_pkg::CR_W-1:0];
                        T_B0C1:  cr_reg[1] <= x_reg - p_reg[pvc_pkg::CR_W-1:0];
                        T_B1C0:  x_reg <= p_reg[pvc_pkg::CR_W-1:0];
                        T_CR2:   cr_reg[2] <= x_reg - p_reg[pvc_pkg::CR_W-1:0];
                        T_DOT1:  d_reg <= p_reg[pvc_pkg::DET_W-1:0];
                        T_DOT2:  d_reg <= d_reg + p_reg[pvc_pkg::DET_W-1:0];
                        T_DOT3:  d_reg <= d_reg + p_reg[pvc_pkg::DET_W-1:0];
                        T_ABS:   ad_reg <= d_reg[pvc_pkg::DET_W-1] ? unsigned'(-d_reg)
                                                                  : unsigned'(d_reg);
                        T_VOL:   vol_reg <= (vol_sum > (VW + 1)'(pvc_pkg::VOL_MAX)) ?
                                            pvc_pkg::VOL_MAX : vol_sum[VW-1:0];
                        T_WX_HI: w_reg[0] <= w_reg[0] + p_ext;
                        T_WY_LO: w_reg[0] <= w_reg[0] + (p_ext <<< SW);
                        T_WY_HI: w_reg[1] <= w_reg[1] + p_ext;
                        T_WZ_LO: w_reg[1] <= w_reg[1] + (p_ext <<< SW);
                        T_WZ_HI: w_reg[2] <= w_reg[2] + p_ext;
                        T_WZ_END:
                        begin
                            w_reg[2] <= w_reg[2] + (p_ext <<< SW);
                            if (wrap_reg)
                            begin
                                f_reg <= f_inc;
                                if (!last_face)
                                begin
                                    state_reg <= S_FACE_RD;
                                end
                                else if (vol_reg == '0)
                                begin
                                    state_reg <= S_FINISH;
                                end
                                else
                                begin
                                    mode_reg  <= DM_CENTRE;
                                    axis_reg  <= '0;
                                    state_reg <= S_DIV_SET;
                                end
                            end
                            else
                            begin
                                j_reg     <= j_inc;
                                cur_reg   <= nxt_reg;
                                state_reg <= S_NEXT_RD;
                            end
                        end
                        default: ;
                    endcase
                end

                S_FINISH:
                begin
                    // Wait here only while an older result is still held.
                    if (res_load)
                    begin
                        res_vol_reg   <= vol_reg;
                        res_deg_reg   <= (vol_reg == '0);
                        res_ovf_reg   <= ovf_reg;
                        for (int k = 0; k < 3; k++)
                        begin
                            res_cen_reg[k] <= (vol_reg == '0) ? '0 : cen_reg[k];
                            fsum_reg[k]    <= '0;
                            w_reg[k]       <= '0;
                        end
                        vc_reg    <= '0;
                        open_reg  <= '0;
                        fc_reg    <= '0;
                        vol_reg   <= '0;
                        ovf_reg   <= 1'b0;
                        state_reg <= S_LOAD;
                    end
                end

                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.volume_x6  = res_vol_reg;
    assign res.centre_x   = res_cen_reg[0];
    assign res.centre_y   = res_cen_reg[1];
    assign res.centre_z   = res_cen_reg[2];
    assign res.degenerate = res_deg_reg;
    assign res.overflow   = res_ovf_reg;

endmodule
